### sv/tgc_pkg.sv
package tgc_pkg;

  localparam int PIX_W     = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  // Signed width of the quadratic numerator: three terms, each below 255^4.
  localparam int NUM_W     = 35;
  localparam int DIVD_W    = NUM_W - 1;
  // Magnitude of the quadratic denominator stays below 255^3.
  localparam int DVSR_W    = 24;
  // Signed difference of two gray levels.
  localparam int OPB_W     = PIX_W + 2;
  localparam int SAT_W     = NUM_W + 1;

  localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUAD = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  low_in;
    logic [PIX_W-1:0]  low_out;
    logic [PIX_W-1:0]  mid_in;
    logic [PIX_W-1:0]  mid_out;
    logic [PIX_W-1:0]  high_in;
    logic [PIX_W-1:0]  high_out;
  } curve_cfg_t;

  typedef struct packed {
    logic             we;
    logic [PIX_W-1:0] addr;
    logic [PIX_W-1:0] data;
  } lut_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a signed value to 0..255.
  function automatic logic [PIX_W-1:0] sat8(input logic signed [SAT_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v[SAT_W-1]) begin
      r = '0;
    end else if (|v[SAT_W-2:PIX_W]) begin
      r = '1;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/three_point_gray_tone_curve_core.sv
// Channel  | handshake             | word
// ---------+-----------------------+-------------------------------------
// in       | in_valid / in_stall   | pixel_in, end_of_image
// out      | out_valid / out_stall | pixel_out, end_of_image_out
// config   | cfg_write             | cfg_index, cfg_data (no read-back)
//
// One pixel per clock once the curve table is built and out_stall is low; an accepted
// word passes the read stage and the output register, and the 256-entry table lookup
// is the only per-pixel work. Reset and every curve register write rebuild the table
// (shared multiplier, bit-serial divider).
// rst is synchronous, active high, loads the defaults; in_stall is high while building.
// A stalled output holds its word; one more pixel enters the read stage, then in_stall rises.
module three_point_gray_tone_curve_core import tgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_in,
  input  logic                 end_of_image,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 end_of_image_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_IN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_OUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_IN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_OUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_IN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_OUT   = 3'd6;

  localparam logic [PIX_W-1:0] MID_DEFAULT  = 8'd128;
  localparam logic [PIX_W-1:0] HIGH_DEFAULT = 8'd255;

  curve_cfg_t       cfg;
  logic             cfg_hit;
  lut_wr_t          lut_wr;
  logic             table_ok;

  // Curve table: one write port for the builder, one registered read port.
  logic [PIX_W-1:0] lut_mem [2**PIX_W];
  logic [PIX_W-1:0] rd_data;

  logic             in_take;
  logic             s1_valid;
  logic             s1_eoi;
  logic             out_adv;

  // Writes to an unused index change nothing and do not rebuild.
  always_comb begin
    case (cfg_index)
      REG_CURVE_MODE, REG_LOW_IN, REG_LOW_OUT, REG_MID_IN,
      REG_MID_OUT, REG_HIGH_IN, REG_HIGH_OUT: cfg_hit = cfg_write;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= '0;
      cfg.low_in   <= '0;
      cfg.low_out  <= '0;
      cfg.mid_in   <= MID_DEFAULT;
      cfg.mid_out  <= MID_DEFAULT;
      cfg.high_in  <= HIGH_DEFAULT;
      cfg.high_out <= HIGH_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CURVE_MODE: cfg.mode     <= cfg_data[MODE_W-1:0];
        REG_LOW_IN:     cfg.low_in   <= cfg_data;
        REG_LOW_OUT:    cfg.low_out  <= cfg_data;
        REG_MID_IN:     cfg.mid_in   <= cfg_data;
        REG_MID_OUT:    cfg.mid_out  <= cfg_data;
        REG_HIGH_IN:    cfg.high_in  <= cfg_data;
        REG_HIGH_OUT:   cfg.high_out <= cfg_data;
        default:        cfg.mode     <= cfg.mode;
      endcase
    end
  end

  // Fills the table with the mapped value of every gray level.
  tgc_build u_build (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .restart  (cfg_hit),
    .lut_wr   (lut_wr),
    .table_ok (table_ok)
  );

  // Builder writes and pixel reads never overlap: reads wait for table_ok.
  always_ff @(posedge clk) begin
    if (lut_wr.we) begin
      lut_mem[lut_wr.addr] <= lut_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_data <= lut_mem[pixel_in];
    end
  end

  // Read stage plus output register; the read stage acts as the skid slot.
  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = !table_ok || (s1_valid && out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_eoi <= end_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      pixel_out        <= rd_data;
      end_of_image_out <= s1_eoi;
    end
  end

  // A curve change closes the input for the rebuild.
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> in_stall)
    else $error("input open right after a curve register write");

  // No lookup while the builder is still writing the table.
  a_build_excl: assert property (@(posedge clk) disable iff (rst)
    lut_wr.we |-> in_stall)
    else $error("pixel read while table is being written");

  // The read stage fills only from an accepted word.
  a_s1_src: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_valid) |-> $past(in_take))
    else $error("read stage filled without an accepted word");

  // A taken output with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !s1_valid |=> !out_valid)
    else $error("output word repeated");

endmodule

### sv/tgc_div.sv
module tgc_div import tgc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy;
  logic              done_r;
  logic [CNT_W-1:0]  count;
  logic [DIVD_W-1:0] quo;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W:0]   rem_sub;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh  = {rem, quo[DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign fits    = !rem_sub[DVSR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy   <= 1'b1;
      done_r <= 1'b0;
      count  <= '0;
      quo    <= req.dividend;
      rem    <= '0;
      dvsr   <= req.divisor;
    end else if (busy) begin
      quo   <= {quo[DIVD_W-2:0], fits};
      rem   <= fits ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
      count <= count + 1'b1;
      if (count == CNT_W'(DIVD_W - 1)) begin
        busy   <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo;

endmodule

### sv/tgc_build.sv
module tgc_build import tgc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  curve_cfg_t cfg,
  input  logic       restart,
  output lut_wr_t    lut_wr,
  output logic       table_ok
);

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_LMUL   = 3'd1;
  localparam logic [2:0] ST_QMUL   = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_LPOST  = 3'd5;
  localparam logic [2:0] ST_QPOST  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // Last product step of the quadratic: the denominator.
  localparam logic [3:0] QS_LAST = 4'd10;

  logic [2:0]       state;
  logic             write_now;
  logic [PIX_W-1:0] entry;
  logic [PIX_W-1:0] result;
  logic [PIX_W-1:0] first_val;
  logic [PIX_W-1:0] lx0, ly0, lx1, ly1;
  logic             second;
  logic             quad;
  logic             q_neg;
  logic [3:0]       step;

  logic signed [NUM_W-1:0]       prod;
  logic signed [NUM_W-1:0]       num;
  logic signed [NUM_W-1:0]       mul_a;
  logic signed [OPB_W-1:0]       mul_b;
  logic signed [NUM_W+OPB_W-1:0] mul_full;
  logic signed [NUM_W-1:0]       mul_p;

  logic signed [OPB_W-1:0] d_p0, d_p1, d_p2, d01, d02, d12, d20;
  logic signed [OPB_W-1:0] lin_dy, lin_dp;
  logic [PIX_W-1:0]        lin_den;
  logic                    strict;

  logic signed [NUM_W-1:0] num_abs, prod_abs, q_mag, q_s;
  logic signed [SAT_W-1:0] lin_sum;
  logic [PIX_W-1:0]        lin_val, quad_val;
  logic [PIX_W:0]          avg_sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic signed [OPB_W-1:0] sdiff(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
    return $signed({2'b00, a}) - $signed({2'b00, b});
  endfunction

  function automatic logic signed [NUM_W-1:0] ext(input logic [PIX_W-1:0] y);
    return $signed({{(NUM_W-PIX_W){1'b0}}, y});
  endfunction

  assign d_p0 = sdiff(entry, cfg.low_in);
  assign d_p1 = sdiff(entry, cfg.mid_in);
  assign d_p2 = sdiff(entry, cfg.high_in);
  assign d01  = sdiff(cfg.low_in, cfg.mid_in);
  assign d02  = sdiff(cfg.low_in, cfg.high_in);
  assign d12  = sdiff(cfg.mid_in, cfg.high_in);
  assign d20  = sdiff(cfg.high_in, cfg.low_in);

  assign lin_dy  = sdiff(ly1, ly0);
  assign lin_dp  = sdiff(entry, lx0);
  assign lin_den = lx1 - lx0;
  assign strict  = (cfg.low_in < cfg.mid_in) && (cfg.mid_in < cfg.high_in);

  // One shared multiplier; the products of the Lagrange form go one per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_LMUL) begin
      mul_a = NUM_W'(lin_dy);
      mul_b = lin_dp;
    end else begin
      case (step)
        4'd0: begin mul_a = ext(cfg.low_out);  mul_b = d_p1; end
        4'd1: begin mul_a = prod;              mul_b = d_p2; end
        4'd2: begin mul_a = prod;              mul_b = d12;  end
        4'd3: begin mul_a = ext(cfg.mid_out);  mul_b = d_p0; end
        4'd4: begin mul_a = prod;              mul_b = d_p2; end
        4'd5: begin mul_a = prod;              mul_b = d20;  end
        4'd6: begin mul_a = ext(cfg.high_out); mul_b = d_p0; end
        4'd7: begin mul_a = prod;              mul_b = d_p1; end
        4'd8: begin mul_a = prod;              mul_b = d01;  end
        4'd9: begin mul_a = NUM_W'(d01);       mul_b = d02;  end
        4'd10: begin mul_a = prod;             mul_b = d12;  end
        default: begin mul_a = '0;             mul_b = '0;   end
      endcase
    end
  end

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[NUM_W-1:0];

  assign num_abs  = num[NUM_W-1] ? -num : num;
  assign prod_abs = prod[NUM_W-1] ? -prod : prod;

  // Quadratic denominator is negative for strictly increasing points.
  assign div_req.start    = (state == ST_DSTART);
  assign div_req.dividend = num_abs[DIVD_W-1:0];
  assign div_req.divisor  = quad ? prod_abs[DVSR_W-1:0]
                                 : {{(DVSR_W-PIX_W){1'b0}}, lin_den};

  tgc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q_mag    = {1'b0, div_rsp.quotient};
  assign q_s      = q_neg ? -q_mag : q_mag;
  assign lin_sum  = SAT_W'(q_s) + $signed({{(SAT_W-PIX_W){1'b0}}, ly0});
  assign lin_val  = sat8(lin_sum);
  assign quad_val = sat8(SAT_W'(q_s));
  assign avg_sum  = {1'b0, first_val} + {1'b0, lin_val};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= ST_START;
      write_now <= 1'b0;
      entry     <= '0;
    end else if (write_now) begin
      write_now <= 1'b0;
      if (entry == '1) begin
        state <= ST_DONE;
      end else begin
        entry <= entry + 1'b1;
        state <= ST_START;
      end
    end else begin
      case (state)
        ST_START: begin
          second <= 1'b0;
          step   <= '0;
          if (entry <= cfg.low_in) begin
            result    <= cfg.low_out;
            write_now <= 1'b1;
          end else if (entry >= cfg.high_in) begin
            result    <= cfg.high_out;
            write_now <= 1'b1;
          end else if (entry == cfg.mid_in) begin
            result    <= cfg.mid_out;
            write_now <= 1'b1;
          end else if (cfg.mode == MODE_QUAD && strict) begin
            quad  <= 1'b1;
            state <= ST_QMUL;
          end else begin
            quad  <= 1'b0;
            state <= ST_LMUL;
            if (entry < cfg.mid_in) begin
              lx0 <= cfg.low_in;
              ly0 <= cfg.low_out;
              lx1 <= cfg.mid_in;
              ly1 <= cfg.mid_out;
            end else begin
              lx0 <= cfg.mid_in;
              ly0 <= cfg.mid_out;
              lx1 <= cfg.high_in;
              ly1 <= cfg.high_out;
            end
          end
        end
        ST_LMUL: begin
          num   <= mul_p;
          state <= ST_DSTART;
        end
        ST_QMUL: begin
          prod <= mul_p;
          step <= step + 1'b1;
          case (step)
            4'd3:       num <= prod;
            4'd6, 4'd9: num <= num + prod;
            default:    num <= num;
          endcase
          if (step == QS_LAST) begin
            state <= ST_DSTART;
          end
        end
        ST_DSTART: begin
          q_neg <= num[NUM_W-1] ^ quad;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= quad ? ST_QPOST : ST_LPOST;
          end
        end
        ST_LPOST: begin
          if (cfg.mode == MODE_AVG && !second) begin
            // second pass: straight line from low point to high point
            first_val <= lin_val;
            second    <= 1'b1;
            lx0       <= cfg.low_in;
            ly0       <= cfg.low_out;
            lx1       <= cfg.high_in;
            ly1       <= cfg.high_out;
            state     <= ST_LMUL;
          end else begin
            result    <= (cfg.mode == MODE_AVG) ? avg_sum[PIX_W:1] : lin_val;
            write_now <= 1'b1;
          end
        end
        ST_QPOST: begin
          result    <= quad_val;
          write_now <= 1'b1;
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: begin
          state <= ST_START;
        end
      endcase
    end
  end

  assign lut_wr.we   = write_now;
  assign lut_wr.addr = entry;
  assign lut_wr.data = result;
  assign table_ok    = (state == ST_DONE) && !write_now;

endmodule
